FILE: sv/qdct_pkg.sv
// Shared constants, codes and types of the quad down-counter timer block.
// No dependencies; every other file imports this package.
package qdct_pkg;

    localparam int NUM_TIMERS    = 4;
    localparam int MAX_TIMERS    = 8;
    localparam int WINDOW_BYTES  = 20;
    localparam int SHARED_WINDOW = 8;
    localparam int ADDR_W        = 12;
    localparam int DATA_W        = 32;
    localparam int IRQ_W         = 4;
    localparam int WORD_W        = 3;

    localparam logic [DATA_W-1:0] FREE_RELOAD = 32'hffff_ffff;

    // control word bits
    localparam int CTL_ENABLE = 0;
    localparam int CTL_USER   = 1;
    localparam int CTL_MASK   = 2;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_TICK  = 2'd2
    } func_t;

    // per-timer window words
    localparam logic [WORD_W-1:0] WORD_LOAD  = 3'd0;
    localparam logic [WORD_W-1:0] WORD_COUNT = 3'd1;
    localparam logic [WORD_W-1:0] WORD_CTL   = 3'd2;
    localparam logic [WORD_W-1:0] WORD_EOI   = 3'd3;
    localparam logic [WORD_W-1:0] WORD_MIS   = 3'd4;

    // shared window words
    localparam logic [WORD_W-1:0] SH_MIS = 3'd0;
    localparam logic [WORD_W-1:0] SH_EOI = 3'd1;
    localparam logic [WORD_W-1:0] SH_RAW = 3'd2;

    typedef struct packed {
        logic [NUM_TIMERS-1:0] hit;
        logic                  shared_hit;
        logic [WORD_W-1:0]     word;
    } dec_t;

    typedef struct packed {
        logic              tick;
        logic              wr_load;
        logic              wr_ctl;
        logic              clr_flag;
        logic [DATA_W-1:0] wdata;
    } chan_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] load;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] ctl;
        logic              flag;
        logic              masked;
        logic              masked_next;
    } chan_stat_t;

endpackage

FILE: sv/qdct_dec.sv
// Address decode: finds the timer or shared window an offset falls in and the word within it.
// Depends on qdct_pkg.
module qdct_dec (
    input  logic [qdct_pkg::ADDR_W-1:0] addr,
    output qdct_pkg::dec_t              dec
);
    import qdct_pkg::*;

    localparam logic [ADDR_W:0] SH_LO = (ADDR_W+1)'(SHARED_WINDOW * WINDOW_BYTES);
    localparam logic [ADDR_W:0] SH_HI = (ADDR_W+1)'((SHARED_WINDOW + 1) * WINDOW_BYTES);

    logic [ADDR_W:0]   addr_x;
    logic [ADDR_W-1:0] offs;
    logic [ADDR_W:0]   lo;
    logic [ADDR_W:0]   hi;

    assign addr_x = {1'b0, addr};

    // Compare against constant window bounds instead of dividing the offset
    always_comb
    begin
        dec  = '0;
        offs = '0;
        lo   = '0;
        hi   = '0;
        for (int n = 0; n < NUM_TIMERS; n++)
        begin
            lo = (ADDR_W+1)'(n * WINDOW_BYTES);
            hi = (ADDR_W+1)'((n + 1) * WINDOW_BYTES);
            if (addr_x >= lo && addr_x < hi)
            begin
                dec.hit[n] = 1'b1;
                offs       = addr - lo[ADDR_W-1:0];
                dec.word   = offs[WORD_W+1:2];
            end
        end
        if (addr_x >= SH_LO && addr_x < SH_HI)
        begin
            dec.shared_hit = 1'b1;
            offs           = addr - SH_LO[ADDR_W-1:0];
            dec.word       = offs[WORD_W+1:2];
        end
    end

endmodule

FILE: sv/qdct_chan.sv
// One timer channel: load count, control word, down counter and raw interrupt flag.
// Depends on qdct_pkg.
module qdct_chan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qdct_pkg::chan_cmd_t  cmd,
    output qdct_pkg::chan_stat_t stat
);
    import qdct_pkg::*;

    logic [DATA_W-1:0] load_reg, load_next;
    logic [DATA_W-1:0] ctl_reg, ctl_next;
    logic [DATA_W-1:0] cnt_reg, cnt_next;
    logic              flag_reg, flag_next;
    logic [DATA_W-1:0] reload;

    assign reload = ctl_reg[CTL_USER] ? load_reg : FREE_RELOAD;

    always_comb
    begin
        load_next = load_reg;
        ctl_next  = ctl_reg;
        cnt_next  = cnt_reg;
        flag_next = flag_reg;
        if (cmd.wr_load)
            load_next = cmd.wdata;
        if (cmd.wr_ctl)
        begin
            ctl_next = cmd.wdata;
            // restart from the reload value the new mode selects
            if (cmd.wdata[CTL_ENABLE])
                cnt_next = cmd.wdata[CTL_USER] ? load_reg : FREE_RELOAD;
        end
        if (cmd.tick && ctl_reg[CTL_ENABLE])
        begin
            if (cnt_reg <= DATA_W'(1))
            begin
                flag_next = 1'b1;
                cnt_next  = reload;
            end
            else
            begin
                cnt_next = cnt_reg - DATA_W'(1);
            end
        end
        if (cmd.clr_flag)
            flag_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= '0;
            ctl_reg  <= '0;
            cnt_reg  <= '0;
            flag_reg <= 1'b0;
        end
        else
        begin
            load_reg <= load_next;
            ctl_reg  <= ctl_next;
            cnt_reg  <= cnt_next;
            flag_reg <= flag_next;
        end
    end

    always_comb
    begin
        stat.load        = load_reg;
        stat.count       = cnt_reg;
        stat.ctl         = ctl_reg;
        stat.flag        = flag_reg;
        stat.masked      = flag_reg & ~ctl_reg[CTL_MASK];
        stat.masked_next = flag_next & ~ctl_next[CTL_MASK];
    end

endmodule

FILE: sv/quad_down_counter_timer_regs.sv
// Top level of the quad down-counter timer: request register, decode, channels, response register.
// Depends on qdct_pkg, qdct_dec and qdct_chan.
//
// Four 32-bit down-counting timers behind a register window per timer (0x14 bytes each) and
// a shared status window at window 8. Each request word is a bus read, a bus write or one
// tick; every request gives exactly one response word with the read data (zero for writes,
// ticks and unknown offsets) and the interrupt lines as they stand after the request.
// A request is taken into the request register, processed in one pass through decode and the
// four channel update paths, and its response is captured in the response register.
// One request per cycle is sustained while rsp_ready is high; the request register frees as the
// response register is taken, so req_ready stays high while a finished response waits only if the pipe is not full.
// Reads of the end-of-interrupt words clear flags; reads and updates of all timers happen in
// the same cycle.
module quad_down_counter_timer_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [1:0]                  func,
    input  logic [qdct_pkg::ADDR_W-1:0] addr,
    input  logic [qdct_pkg::DATA_W-1:0] wdata,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [qdct_pkg::DATA_W-1:0] rdata,
    output logic [qdct_pkg::IRQ_W-1:0]  irq_lines
);
    import qdct_pkg::*;

    logic              req_vld_reg;
    logic [1:0]        func_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] wdata_reg;

    logic              rsp_vld_reg;
    logic [DATA_W-1:0] rdata_reg, rdata_next;
    logic [IRQ_W-1:0]  irq_reg, irq_next;

    logic              advance;
    logic              is_read;
    logic              is_write;
    logic              is_tick;
    dec_t              dec;
    chan_cmd_t         cmd  [NUM_TIMERS];
    chan_stat_t        stat [NUM_TIMERS];
    logic [MAX_TIMERS-1:0] masked_pad;
    logic [MAX_TIMERS-1:0] raw_pad;
    logic [MAX_TIMERS-1:0] masked_next_pad;

    assign advance   = req_vld_reg && (!rsp_vld_reg || rsp_ready);
    assign req_ready = !req_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_vld_reg <= 1'b0;
        else if (req_ready)
            req_vld_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            func_reg  <= func;
            addr_reg  <= addr;
            wdata_reg <= wdata;
        end
    end

    qdct_dec u_dec (
        .addr (addr_reg),
        .dec  (dec)
    );

    always_comb
    begin
        is_read  = 1'b0;
        is_write = 1'b0;
        is_tick  = 1'b0;
        case (func_reg)
            FUNC_READ:  is_read  = 1'b1;
            FUNC_WRITE: is_write = 1'b1;
            FUNC_TICK:  is_tick  = 1'b1;
            default:    ;
        endcase
    end

    // Commands only fire on the cycle the request moves into the response register
    always_comb
    begin
        for (int n = 0; n < NUM_TIMERS; n++)
        begin
            cmd[n].tick     = advance && is_tick;
            cmd[n].wr_load  = advance && is_write && dec.hit[n] && dec.word == WORD_LOAD;
            cmd[n].wr_ctl   = advance && is_write && dec.hit[n] && dec.word == WORD_CTL;
            cmd[n].clr_flag = advance && is_read &&
                              ((dec.hit[n] && dec.word == WORD_EOI) ||
                               (dec.shared_hit && dec.word == SH_EOI));
            cmd[n].wdata    = wdata_reg;
        end
    end

    for (genvar g = 0; g < NUM_TIMERS; g++)
    begin : g_chan
        qdct_chan u_chan (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd[g]),
            .stat  (stat[g])
        );
    end

    always_comb
    begin
        masked_pad      = '0;
        raw_pad         = '0;
        masked_next_pad = '0;
        for (int n = 0; n < NUM_TIMERS; n++)
        begin
            masked_pad[n]      = stat[n].masked;
            raw_pad[n]         = stat[n].flag;
            masked_next_pad[n] = stat[n].masked_next;
        end
    end

    always_comb
    begin
        rdata_next = '0;
        if (is_read)
        begin
            for (int n = 0; n < NUM_TIMERS; n++)
            begin
                if (dec.hit[n])
                begin
                    case (dec.word)
                        WORD_LOAD:  rdata_next = stat[n].load;
                        WORD_COUNT: rdata_next = stat[n].count;
                        WORD_CTL:   rdata_next = stat[n].ctl;
                        WORD_MIS:   rdata_next = DATA_W'(stat[n].masked);
                        default:    ;
                    endcase
                end
            end
            if (dec.shared_hit)
            begin
                case (dec.word)
                    SH_MIS:  rdata_next = DATA_W'(masked_pad);
                    SH_RAW:  rdata_next = DATA_W'(raw_pad);
                    default: ;
                endcase
            end
        end
        irq_next = masked_next_pad[IRQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_vld_reg <= 1'b0;
        else if (!rsp_vld_reg || rsp_ready)
            rsp_vld_reg <= req_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rdata_reg <= rdata_next;
            irq_reg   <= irq_next;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rdata     = rdata_reg;
    assign irq_lines = irq_reg;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for quad_down_counter_timer_regs: bus reads, bus writes and ticks
// against a cycle-free predictor of the four timers, with random idling on both channels.
// Depends on qdct_pkg and the RTL of the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qdct_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam logic [DATA_W-1:0] EN_BIT   = 32'd1 << CTL_ENABLE;
    localparam logic [DATA_W-1:0] USER_BIT = 32'd1 << CTL_USER;
    localparam logic [DATA_W-1:0] MASK_BIT = 32'd1 << CTL_MASK;
    localparam int RANDOM_WORDS = 1850;
    localparam int CALM_WORDS   = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct {
        logic [DATA_W-1:0] rdata;
        logic [IRQ_W-1:0]  irq;
    } timer_rsp_t;

    class timer_scoreboard;
        logic [DATA_W-1:0] load_cnt [NUM_TIMERS];
        logic [DATA_W-1:0] ctl_word [NUM_TIMERS];
        logic [DATA_W-1:0] cur_cnt  [NUM_TIMERS];
        bit                flag     [NUM_TIMERS];
        timer_rsp_t        rsp_q[$];
        int n_reads, n_writes, n_ticks, n_expiries, n_checked, n_errors;

        function new();
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                load_cnt[t] = '0;
                ctl_word[t] = '0;
                cur_cnt[t]  = '0;
                flag[t]     = 1'b0;
            end
            n_reads = 0; n_writes = 0; n_ticks = 0;
            n_expiries = 0; n_checked = 0; n_errors = 0;
        endfunction

        function logic [DATA_W-1:0] reload(int t);
            return ctl_word[t][CTL_USER] ? load_cnt[t] : FREE_RELOAD;
        endfunction

        function logic [DATA_W-1:0] masked_flags();
            logic [DATA_W-1:0] v;
            v = '0;
            for (int t = 0; t < NUM_TIMERS; t++)
                if (flag[t] && !ctl_word[t][CTL_MASK])
                    v[t] = 1'b1;
            return v;
        endfunction

        function logic [DATA_W-1:0] raw_flags();
            logic [DATA_W-1:0] v;
            v = '0;
            for (int t = 0; t < NUM_TIMERS; t++)
                v[t] = flag[t];
            return v;
        endfunction

        function logic [DATA_W-1:0] bus_read(int unsigned win, int unsigned wrd);
            logic [DATA_W-1:0] v;
            v = '0;
            if (win < NUM_TIMERS)
            begin
                case (wrd)
                    WORD_LOAD:  v = load_cnt[win];
                    WORD_COUNT: v = cur_cnt[win];
                    WORD_CTL:   v = ctl_word[win];
                    WORD_EOI:   flag[win] = 1'b0;
                    WORD_MIS:   v = (masked_flags() >> win) & 32'd1;
                    default:    v = '0;
                endcase
            end
            else if (win == SHARED_WINDOW)
            begin
                case (wrd)
                    SH_MIS: v = masked_flags();
                    SH_EOI:
                        for (int t = 0; t < NUM_TIMERS; t++)
                            flag[t] = 1'b0;
                    SH_RAW: v = raw_flags();
                    default: v = '0;
                endcase
            end
            return v;
        endfunction

        function void bus_write(int unsigned win, int unsigned wrd, logic [DATA_W-1:0] d);
            if (win >= NUM_TIMERS)
                return;
            if (wrd == WORD_LOAD)
                load_cnt[win] = d;
            else if (wrd == WORD_CTL)
            begin
                ctl_word[win] = d;
                // restart from the reload value only when enabled, else freeze
                if (d[CTL_ENABLE])
                    cur_cnt[win] = reload(win);
            end
        endfunction

        function void tick_timers();
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                if (!ctl_word[t][CTL_ENABLE])
                    continue;
                if (cur_cnt[t] <= 1)
                begin
                    flag[t]    = 1'b1;
                    cur_cnt[t] = reload(t);
                    n_expiries++;
                end
                else
                    cur_cnt[t] = cur_cnt[t] - 1;
            end
        endfunction

        function void note_request(logic [1:0] f, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
            int unsigned win, wrd;
            timer_rsp_t exp_rsp;
            logic [DATA_W-1:0] m;
            win = a / WINDOW_BYTES;
            wrd = (a % WINDOW_BYTES) >> 2;
            exp_rsp.rdata = '0;
            case (f)
                FUNC_READ:
                begin
                    exp_rsp.rdata = bus_read(win, wrd);
                    n_reads++;
                end
                FUNC_WRITE:
                begin
                    bus_write(win, wrd, d);
                    n_writes++;
                end
                FUNC_TICK:
                begin
                    tick_timers();
                    n_ticks++;
                end
                default: ;
            endcase
            m = masked_flags();
            exp_rsp.irq = m[IRQ_W-1:0];
            rsp_q.push_back(exp_rsp);
        endfunction

        function void check_response(logic [DATA_W-1:0] rd, logic [IRQ_W-1:0] irq);
            timer_rsp_t exp_rsp;
            if (rsp_q.size() == 0)
            begin
                $display("%0t: response word with nothing expected: rdata %h irq %h",
                         $time, rd, irq);
                n_errors++;
                return;
            end
            exp_rsp = rsp_q.pop_front();
            n_checked++;
            if (rd !== exp_rsp.rdata)
            begin
                $display("%0t: rdata mismatch: expected %h, actual %h",
                         $time, exp_rsp.rdata, rd);
                n_errors++;
            end
            if (irq !== exp_rsp.irq)
            begin
                $display("%0t: irq_lines mismatch: expected %h, actual %h",
                         $time, exp_rsp.irq, irq);
                n_errors++;
            end
        endfunction

        function int pending();
            return rsp_q.size();
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    logic [1:0]        func      = FUNC_READ;
    logic [ADDR_W-1:0] addr      = '0;
    logic [DATA_W-1:0] wdata     = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    logic [DATA_W-1:0] rdata;
    logic [IRQ_W-1:0]  irq_lines;

    timer_scoreboard sb;
    bit calm      = 1'b0;
    bit quiet     = 1'b0;
    bit want_hold = 1'b0;
    int cycle_count = 0;

    quad_down_counter_timer_regs dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .func      (func),
        .addr      (addr),
        .wdata     (wdata),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rdata     (rdata),
        .irq_lines (irq_lines)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles with %0d words outstanding",
                     cycle_count, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] reg_addr(int win, int wrd);
        return ADDR_W'(win * WINDOW_BYTES + wrd * 4);
    endfunction

    task automatic send_word(input logic [1:0] f, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] d);
        int gap;
        gap = 0;
        if (!calm && !quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 14);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= f;
        addr      <= a;
        wdata     <= d;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        sb.note_request(f, a, d);
    endtask

    task automatic send_random_word();
        int pick, win;
        logic [1:0]        f;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] d;
        pick = $urandom_range(0, 99);
        win  = $urandom_range(0, NUM_TIMERS - 1);
        f    = FUNC_TICK;
        a    = ADDR_W'($urandom_range(0, 4095));
        d    = $urandom();
        if (pick < 35)
            f = FUNC_TICK;
        else if (pick < 50)
        begin
            f = FUNC_READ;
            if ($urandom_range(0, 4) == 0)
                win = SHARED_WINDOW;
            a = reg_addr(win, $urandom_range(0, 4));
        end
        else if (pick < 60)
        begin
            // short reloads keep expiries frequent
            f = FUNC_WRITE;
            a = reg_addr(win, WORD_LOAD);
            if ($urandom_range(0, 4) != 0)
                d = $urandom_range(0, 24);
        end
        else if (pick < 70)
        begin
            f = FUNC_WRITE;
            a = reg_addr(win, WORD_CTL);
            if ($urandom_range(0, 2) != 0)
                d[DATA_W-1:3] = '0;
            d[CTL_ENABLE] = ($urandom_range(0, 4) != 0);
            d[CTL_USER]   = ($urandom_range(0, 5) != 0);
        end
        else if (pick < 78)
        begin
            f = FUNC_READ;
            if ($urandom_range(0, 3) == 0)
                a = reg_addr(SHARED_WINDOW, SH_EOI);
            else
                a = reg_addr(win, WORD_EOI);
        end
        else if (pick < 90)
            f = 2'($urandom_range(0, 3));
        else
        begin
            f = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
            a = reg_addr($urandom_range(0, SHARED_WINDOW), $urandom_range(0, 4));
        end
        send_word(f, a, d);
    endtask

    // response side: random stalls, one long hold-off on request
    initial
    begin
        int stall_left, run_left, hold_left;
        stall_left = 0;
        run_left   = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
                sb.check_response(rdata, irq_lines);
            if (want_hold)
            begin
                hold_left = HOLD_CYCLES;
                want_hold = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (calm || quiet)
                rsp_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (run_left > 0)
            begin
                run_left--;
                rsp_ready <= 1'b1;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                run_left = $urandom_range(1, 30) - 1;
                rsp_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // timer 0 in user mode: count down from 3 and expire
        send_word(FUNC_READ,  reg_addr(0, WORD_LOAD), '0);
        send_word(FUNC_READ,  reg_addr(SHARED_WINDOW, SH_RAW), '0);
        send_word(FUNC_WRITE, reg_addr(0, WORD_LOAD), 32'd3);
        send_word(FUNC_WRITE, reg_addr(0, WORD_CTL), EN_BIT | USER_BIT);
        repeat (3) send_word(FUNC_TICK, '0, '0);
        send_word(FUNC_READ,  reg_addr(0, WORD_COUNT), '0);
        send_word(FUNC_READ,  reg_addr(0, WORD_MIS), '0);
        send_word(FUNC_READ,  reg_addr(SHARED_WINDOW, SH_MIS), '0);
        send_word(FUNC_READ,  reg_addr(0, WORD_EOI), '0);
        // zero reload expires on every tick; masked so no line
        send_word(FUNC_WRITE, reg_addr(1, WORD_LOAD), '0);
        send_word(FUNC_WRITE, reg_addr(1, WORD_CTL), EN_BIT | USER_BIT | MASK_BIT);
        send_word(FUNC_TICK,  12'hfff, 32'hffff_ffff);
        send_word(FUNC_READ,  reg_addr(SHARED_WINDOW, SH_RAW), '0);
        // free-running and all-ones control
        send_word(FUNC_WRITE, reg_addr(2, WORD_LOAD), 32'hffff_ffff);
        send_word(FUNC_WRITE, reg_addr(2, WORD_CTL), EN_BIT);
        send_word(FUNC_WRITE, reg_addr(3, WORD_CTL), 32'hffff_ffff);
        // writes to read-only words and the shared window drop; then a read beyond the timers
        send_word(FUNC_WRITE, reg_addr(0, WORD_COUNT), 32'h1234_5678);
        send_word(FUNC_WRITE, reg_addr(0, WORD_EOI), 32'hffff_ffff);
        send_word(FUNC_WRITE, reg_addr(SHARED_WINDOW, SH_MIS), 32'hffff_ffff);
        send_word(FUNC_READ,  reg_addr(5, WORD_LOAD), '0);
        send_word(FUNC_READ,  reg_addr(SHARED_WINDOW, 3), '0);
        send_word(FUNC_NONE,  reg_addr(0, WORD_LOAD), 32'hdead_beef);
        send_word(FUNC_READ,  12'hfff, '0);
        send_word(FUNC_TICK,  '0, '0);
        send_word(FUNC_READ,  reg_addr(SHARED_WINDOW, SH_EOI), '0);
        // disabled counter holds its count
        send_word(FUNC_WRITE, reg_addr(0, WORD_CTL), '0);
        send_word(FUNC_TICK,  '0, '0);
        send_word(FUNC_READ,  reg_addr(0, WORD_COUNT), '0);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            calm  = (i >= RANDOM_WORDS - CALM_WORDS);
            quiet = ((i / 120) % 4 == 3);
            if (i == 500)
                want_hold = 1'b1;
            send_random_word();
        end
        req_valid <= 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d reads, %0d writes and %0d ticks with %0d counter expiries.",
                 sb.n_reads, sb.n_writes, sb.n_ticks, sb.n_expiries);
        $display("Compared %0d response words, %0d mismatches, in %0d cycles.",
                 sb.n_checked, sb.n_errors, cycle_count);
        if (sb.n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
